/* rtl/imhq_pkg.sv */
package imhq_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 8;
    localparam int KEY_IN_W = 32;
    localparam int RPOS_W   = 9;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 9;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT,
        MODE_REMOVE,
        MODE_POP,
        MODE_READ
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_PRESENT,
        ST_ABSENT,
        ST_EMPTY,
        ST_FULL,
        ST_RANGE
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_UP_CHECK,
        S_UP_CMP,
        S_DN_CHECK,
        S_DN_L,
        S_DN_R,
        S_DN_MOVE,
        S_FILL_RD,
        S_DONE
    } ctl_state_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CLEAR,
        OP_ACCEPT,
        OP_STATUS,
        OP_INS_START,
        OP_REM_START,
        OP_POP_START,
        OP_READ_OUT,
        OP_UP_PLACE,
        OP_UP_READ,
        OP_UP_MOVE,
        OP_DN_READ_L,
        OP_DN_TAKE_L,
        OP_DN_TAKE_R,
        OP_DN_MOVE,
        OP_FILL,
        OP_FILL_LOAD,
        OP_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic  clear_last;
        logic  out_free;
        mode_t mode;
        logic  present;
        logic  full;
        logic  empty;
        logic  rpos_bad;
        logic  at_root;
        logic  parent_less;
        logic  kid_in;
        logic  kid_last;
        logic  hole_last;
    } dp_stat_t;

endpackage

/* rtl/imhq_ram.sv */
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/imhq_ctrl.sv */
module imhq_ctrl import imhq_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NOP;
        cmd.status = ST_OK;
        s_ready    = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.op = OP_CLEAR;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_ACCEPT;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                state_next = S_DONE;
                case (stat.mode)
                    MODE_INSERT: begin
                        if (stat.present) begin
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_PRESENT;
                        end else if (stat.full) begin
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_FULL;
                        end else begin
                            cmd.op     = OP_INS_START;
                            state_next = S_UP_CHECK;
                        end
                    end
                    MODE_REMOVE: begin
                        if (!stat.present) begin
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_ABSENT;
                        end else begin
                            cmd.op     = OP_REM_START;
                            state_next = S_DN_CHECK;
                        end
                    end
                    MODE_POP: begin
                        if (stat.empty) begin
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_EMPTY;
                        end else begin
                            cmd.op     = OP_POP_START;
                            state_next = S_DN_CHECK;
                        end
                    end
                    default: begin
                        if (stat.rpos_bad) begin
                            cmd.op     = OP_STATUS;
                            cmd.status = ST_RANGE;
                        end else begin
                            cmd.op = OP_READ_OUT;
                        end
                    end
                endcase
            end
            S_UP_CHECK: begin
                if (stat.at_root) begin
                    cmd.op     = OP_UP_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_UP_READ;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat.parent_less) begin
                    cmd.op     = OP_UP_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.op     = OP_UP_MOVE;
                    state_next = S_UP_CHECK;
                end
            end
            S_DN_CHECK: begin
                if (stat.kid_in) begin
                    cmd.op     = OP_DN_READ_L;
                    state_next = S_DN_L;
                end else begin
                    cmd.op     = OP_FILL;
                    state_next = stat.hole_last ? S_DONE : S_FILL_RD;
                end
            end
            S_DN_L: begin
                cmd.op     = OP_DN_TAKE_L;
                state_next = stat.kid_last ? S_DN_MOVE : S_DN_R;
            end
            S_DN_R: begin
                cmd.op     = OP_DN_TAKE_R;
                state_next = S_DN_MOVE;
            end
            S_DN_MOVE: begin
                cmd.op     = OP_DN_MOVE;
                state_next = S_DN_CHECK;
            end
            S_FILL_RD: begin
                cmd.op     = OP_FILL_LOAD;
                state_next = S_UP_CHECK;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/imhq_datapath.sv */
module imhq_datapath import imhq_pkg::*; #(
    parameter int HEAP_DEPTH = 256,
    parameter int ID_COUNT   = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ID_W-1:0]     s_item_id,
    input  logic [KEY_IN_W-1:0] s_item_key,
    input  logic [RPOS_W-1:0]   s_read_position,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_out_id,
    output logic [KEY_IN_W-1:0] m_out_key,
    output logic [COUNT_W-1:0]  m_entry_count
);

    localparam int PW   = $clog2(HEAP_DEPTH + 1);
    localparam int AW   = $clog2(HEAP_DEPTH);
    localparam int IW   = $clog2(ID_COUNT);
    localparam int EW   = KEY_WIDTH + ID_W;
    localparam int CMPW = (PW > RPOS_W) ? PW : RPOS_W;

    mode_t               mode_reg, mode_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [RPOS_W-1:0]   rpos_reg, rpos_next;
    logic [PW-1:0]       count_reg, count_next;
    logic [PW-1:0]       last_reg, last_next;
    logic [PW-1:0]       pos_reg, pos_next;
    logic [PW:0]         kid_reg, kid_next;
    logic [EW-1:0]       ent_reg, ent_next;
    logic [EW-1:0]       cand_reg, cand_next;
    logic [IW-1:0]       clr_reg, clr_next;
    status_t             res_status_reg, res_status_next;
    logic [ID_W-1:0]     res_id_reg, res_id_next;
    logic [KEY_IN_W-1:0] res_key_reg, res_key_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [ID_W-1:0]     m_id_reg, m_id_next;
    logic [KEY_IN_W-1:0] m_key_reg, m_key_next;
    logic [COUNT_W-1:0]  m_count_reg, m_count_next;

    logic [IW:0]         fold_rem;
    logic [ID_W-1:0]     id_fold;
    logic [PW:0]         kid_w;

    logic                heap_we;
    logic [AW-1:0]       heap_waddr, heap_raddr;
    logic [EW-1:0]       heap_wdata, heap_rd;
    logic                pos_we;
    logic [IW-1:0]       pos_waddr, pos_raddr;
    logic [PW-1:0]       pos_wdata, pos_rd;

    imhq_ram #(.WIDTH(EW), .DEPTH(HEAP_DEPTH)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rd)
    );

    imhq_ram #(.WIDTH(PW), .DEPTH(ID_COUNT)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rd)
    );

    // id folded into the table range, one restoring step per bit
    always_comb begin
        fold_rem = '0;
        for (int i = ID_W - 1; i >= 0; i--) begin
            fold_rem = {fold_rem[IW-1:0], s_item_id[i]};
            if (fold_rem >= (IW + 1)'(ID_COUNT)) begin
                fold_rem = fold_rem - (IW + 1)'(ID_COUNT);
            end
        end
        id_fold = ID_W'(fold_rem);
    end

    assign kid_w = {pos_reg, 1'b0};

    always_comb begin
        stat.clear_last  = (clr_reg == IW'(ID_COUNT - 1));
        stat.out_free    = !m_valid_reg || m_ready;
        stat.mode        = mode_reg;
        stat.present     = (pos_rd != '0) && (pos_rd <= count_reg);
        stat.full        = (count_reg == PW'(HEAP_DEPTH));
        stat.empty       = (count_reg == '0);
        stat.rpos_bad    = (rpos_reg == '0) || (CMPW'(rpos_reg) > CMPW'(count_reg));
        stat.at_root     = (pos_reg == PW'(1));
        stat.parent_less = (heap_rd[EW-1:ID_W] < ent_reg[EW-1:ID_W]);
        stat.kid_in      = (kid_w <= (PW + 1)'(last_reg));
        stat.kid_last    = (kid_reg == (PW + 1)'(last_reg));
        stat.hole_last   = (pos_reg == last_reg);
    end

    always_comb begin
        mode_next       = mode_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        rpos_next       = rpos_reg;
        count_next      = count_reg;
        last_next       = last_reg;
        pos_next        = pos_reg;
        kid_next        = kid_reg;
        ent_next        = ent_reg;
        cand_next       = cand_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_key_next    = res_key_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_id_next       = m_id_reg;
        m_key_next      = m_key_reg;
        m_count_next    = m_count_reg;
        heap_we         = 1'b0;
        heap_waddr      = AW'(pos_reg - 1'b1);
        heap_wdata      = ent_reg;
        heap_raddr      = '0;
        pos_we          = 1'b0;
        pos_waddr       = IW'(ent_reg[ID_W-1:0]);
        pos_wdata       = pos_reg;
        pos_raddr       = IW'(id_fold);
        case (cmd.op)
            OP_CLEAR: begin
                pos_we    = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            OP_ACCEPT: begin
                mode_next       = mode_t'(s_mode);
                id_next         = id_fold;
                key_next        = KEY_WIDTH'(s_item_key);
                rpos_next       = s_read_position;
                res_status_next = ST_OK;
                res_id_next     = '0;
                res_key_next    = '0;
                heap_raddr      = (mode_t'(s_mode) == MODE_POP) ? '0
                                : AW'(s_read_position - 1'b1);
            end
            OP_STATUS: begin
                res_status_next = cmd.status;
            end
            OP_INS_START: begin
                count_next = PW'(count_reg + 1'b1);
                pos_next   = PW'(count_reg + 1'b1);
                ent_next   = {key_reg, id_reg};
            end
            OP_REM_START: begin
                pos_we    = 1'b1;
                pos_waddr = IW'(id_reg);
                pos_wdata = '0;
                pos_next  = pos_rd;
                last_next = count_reg;
            end
            OP_POP_START: begin
                res_id_next  = heap_rd[ID_W-1:0];
                res_key_next = KEY_IN_W'(heap_rd[EW-1:ID_W]);
                pos_we       = 1'b1;
                pos_waddr    = IW'(heap_rd[ID_W-1:0]);
                pos_wdata    = '0;
                pos_next     = PW'(1);
                last_next    = count_reg;
            end
            OP_READ_OUT: begin
                res_id_next  = heap_rd[ID_W-1:0];
                res_key_next = KEY_IN_W'(heap_rd[EW-1:ID_W]);
            end
            OP_UP_PLACE: begin
                heap_we = 1'b1;
                pos_we  = 1'b1;
            end
            OP_UP_READ: begin
                heap_raddr = AW'((pos_reg >> 1) - 1'b1);
            end
            OP_UP_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = heap_rd;
                pos_we     = 1'b1;
                pos_waddr  = IW'(heap_rd[ID_W-1:0]);
                pos_next   = pos_reg >> 1;
            end
            OP_DN_READ_L: begin
                heap_raddr = AW'(kid_w - 1'b1);
                kid_next   = kid_w;
            end
            OP_DN_TAKE_L: begin
                cand_next  = heap_rd;
                heap_raddr = AW'(kid_reg);
            end
            OP_DN_TAKE_R: begin
                if (heap_rd[EW-1:ID_W] < cand_reg[EW-1:ID_W]) begin
                    cand_next = heap_rd;
                    kid_next  = kid_reg + 1'b1;
                end
            end
            OP_DN_MOVE: begin
                heap_we    = 1'b1;
                heap_wdata = cand_reg;
                pos_we     = 1'b1;
                pos_waddr  = IW'(cand_reg[ID_W-1:0]);
                pos_next   = PW'(kid_reg);
            end
            OP_FILL: begin
                count_next = count_reg - 1'b1;
                heap_raddr = AW'(last_reg - 1'b1);
            end
            OP_FILL_LOAD: begin
                ent_next = heap_rd;
            end
            OP_DONE: begin
                m_valid_next  = 1'b1;
                m_status_next = res_status_reg;
                m_id_next     = res_id_reg;
                m_key_next    = res_key_reg;
                m_count_next  = COUNT_W'(count_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            mode_reg    <= MODE_INSERT;
        end else begin
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            mode_reg    <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg         <= id_next;
        key_reg        <= key_next;
        rpos_reg       <= rpos_next;
        last_reg       <= last_next;
        pos_reg        <= pos_next;
        kid_reg        <= kid_next;
        ent_reg        <= ent_next;
        cand_reg       <= cand_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_key_reg    <= res_key_next;
        m_status_reg   <= m_status_next;
        m_id_reg       <= m_id_next;
        m_key_reg      <= m_key_next;
        m_count_reg    <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_out_id      = m_id_reg;
    assign m_out_key     = m_key_reg;
    assign m_entry_count = m_count_reg;

`ifndef ASSERT_OFF
    a_heap_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        heap_we |-> (pos_reg != '0) && (pos_reg <= count_reg))
        else $error("heap write outside occupied slots");

    a_count_steps_by_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == $past(count_reg)) || (count_reg == PW'($past(count_reg) + 1'b1))
        || (count_reg == PW'($past(count_reg) - 1'b1)))
        else $error("entry count jumped");

    a_child_within_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DN_MOVE) |-> (kid_reg <= (PW + 1)'(last_reg)))
        else $error("hole moved past last slot");
`endif

endmodule

/* rtl/indexed_min_heap_queue.sv */
// path: a read or a rejected op goes from the accepted beat through the lookup and done
// states to m_valid; a walk adds the check, left, right and move states per level down (no
// right state on a lone left child) and the check and compare states per level up
// flow: one beat at a time, the next request can be taken in the cycle in which m_valid rises;
// the heap ram (one read and one write per cycle) and the sift loops set the rate
// reset: synchronous active-low aresetn, then a clearing pass over every entry of the
// position table during which s_ready stays low
module indexed_min_heap_queue import imhq_pkg::*; #(
    parameter int HEAP_DEPTH = 256,
    parameter int ID_COUNT   = 256,
    parameter int KEY_WIDTH  = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    // request channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ID_W-1:0]     s_item_id,
    input  logic [KEY_IN_W-1:0] s_item_key,
    input  logic [RPOS_W-1:0]   s_read_position,
    // result channel, one beat per request
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [ID_W-1:0]     m_out_id,
    output logic [KEY_IN_W-1:0] m_out_key,
    output logic [COUNT_W-1:0]  m_entry_count
);

    // controller issues one datapath op per cycle and steers on the flags
    dp_cmd_t  cmd;
    dp_stat_t stat;

    imhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // heap ram, position table, count and the result register
    imhq_datapath #(
        .HEAP_DEPTH (HEAP_DEPTH),
        .ID_COUNT   (ID_COUNT),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_mode          (s_mode),
        .s_item_id       (s_item_id),
        .s_item_key      (s_item_key),
        .s_read_position (s_read_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_key       (m_out_key),
        .m_entry_count   (m_entry_count)
    );

endmodule

/* bench/indexed_min_heap_queue_tb.sv */
`timescale 1ns / 100ps

module indexed_min_heap_queue_tb import imhq_pkg::*; ();

    localparam int DEPTH      = 256;
    localparam int IDS        = 256;
    localparam int RAND_ITEMS = 750;
    localparam int CALM_ITEMS = 100;   // tail of the run with no idling
    localparam int HOLD_LEN   = 300;   // long receiver hold-off
    localparam int WD_LIMIT   = 6000;  // cycles with no beat on either side

    typedef struct packed {
        status_t                  status;
        logic [ID_W-1:0]          id;
        logic [KEY_IN_W-1:0]      key;
        logic [COUNT_W-1:0]       count;
    } heap_result_t;

    typedef struct {
        mode_t                    mode;
        logic [ID_W-1:0]          id;
        logic [KEY_IN_W-1:0]      key;
        logic [RPOS_W-1:0]        rpos;
        bit                       typed;   // expected result given in the row
        heap_result_t             res;
    } heap_row_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [MODE_W-1:0]   s_mode;
    logic [ID_W-1:0]     s_item_id;
    logic [KEY_IN_W-1:0] s_item_key;
    logic [RPOS_W-1:0]   s_read_position;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [ID_W-1:0]     m_out_id;
    logic [KEY_IN_W-1:0] m_out_key;
    logic [COUNT_W-1:0]  m_entry_count;

    always #10 aclk = ~aclk;

    indexed_min_heap_queue u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_item_id       (s_item_id),
        .s_item_key      (s_item_key),
        .s_read_position (s_read_position),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_id        (m_out_id),
        .m_out_key       (m_out_key),
        .m_entry_count   (m_entry_count)
    );

    // shadow copy of the heap, slots numbered from 1
    logic [KEY_IN_W-1:0] shadow_key [1:DEPTH];
    logic [ID_W-1:0]     shadow_id  [1:DEPTH];
    int                  shadow_pos [0:IDS-1];
    int                  shadow_count;

    heap_result_t pending_results [$];
    int  mismatches;
    int  results_seen;
    int  peak_count;
    int  status_hits [0:7];
    bit  calm;
    bit  hold_req;
    int  quiet_cycles;

    // ---------------------------------------------------------------
    // heap predictor
    // ---------------------------------------------------------------
    task automatic shadow_sift_up(input int p);
        int                  up;
        logic [KEY_IN_W-1:0] tk;
        logic [ID_W-1:0]     ti;
        while (p > 1) begin
            up = p >> 1;
            if (shadow_key[up] < shadow_key[p]) break;
            // equal keys still swap
            tk = shadow_key[up]; shadow_key[up] = shadow_key[p]; shadow_key[p] = tk;
            ti = shadow_id[up];  shadow_id[up]  = shadow_id[p];  shadow_id[p]  = ti;
            shadow_pos[shadow_id[p]] = p;
            p = up;
        end
        shadow_pos[shadow_id[p]] = p;
    endtask

    task automatic shadow_remove_at(input int p);
        int last;
        int hole;
        int kid;
        last = shadow_count;
        hole = p;
        kid  = 2 * p;
        shadow_pos[shadow_id[p]] = 0;
        // hole walks down to a leaf along the smaller child, left on a tie
        while (kid <= last) begin
            if (kid != last && shadow_key[kid + 1] < shadow_key[kid]) kid++;
            shadow_key[hole] = shadow_key[kid];
            shadow_id[hole]  = shadow_id[kid];
            shadow_pos[shadow_id[hole]] = hole;
            hole = kid;
            kid  = 2 * kid;
        end
        shadow_count--;
        if (hole != last) begin
            shadow_key[hole] = shadow_key[last];
            shadow_id[hole]  = shadow_id[last];
            shadow_sift_up(hole);
        end
    endtask

    function automatic bit id_present(input logic [ID_W-1:0] id);
        return shadow_pos[id] != 0 && shadow_pos[id] <= shadow_count;
    endfunction

    task automatic heap_apply(input mode_t mode, input logic [ID_W-1:0] id,
                              input logic [KEY_IN_W-1:0] key,
                              input logic [RPOS_W-1:0] rpos,
                              output heap_result_t res);
        res = '0;
        res.status = ST_OK;
        case (mode)
            MODE_INSERT: begin
                if (id_present(id)) res.status = ST_PRESENT;
                else if (shadow_count >= DEPTH) res.status = ST_FULL;
                else begin
                    shadow_count++;
                    shadow_key[shadow_count] = key;
                    shadow_id[shadow_count]  = id;
                    shadow_sift_up(shadow_count);
                end
            end
            MODE_REMOVE: begin
                if (!id_present(id)) res.status = ST_ABSENT;
                else shadow_remove_at(shadow_pos[id]);
            end
            MODE_POP: begin
                if (shadow_count == 0) res.status = ST_EMPTY;
                else begin
                    res.id  = shadow_id[1];
                    res.key = shadow_key[1];
                    shadow_remove_at(1);
                end
            end
            default: begin
                if (rpos == 0 || rpos > shadow_count) res.status = ST_RANGE;
                else begin
                    res.id  = shadow_id[rpos];
                    res.key = shadow_key[rpos];
                end
            end
        endcase
        res.count = shadow_count[COUNT_W-1:0];
        if (shadow_count > peak_count) peak_count = shadow_count;
    endtask

    // ---------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------
    task automatic send_beat(input mode_t mode, input logic [ID_W-1:0] id,
                             input logic [KEY_IN_W-1:0] key,
                             input logic [RPOS_W-1:0] rpos,
                             input bit typed, input heap_result_t typed_res);
        heap_result_t res;
        int           gap;
        s_valid         <= 1'b1;
        s_mode          <= mode;
        s_item_id       <= id;
        s_item_key      <= key;
        s_read_position <= rpos;
        do @(posedge aclk); while (!s_ready);
        heap_apply(mode, id, key, rpos, res);
        // rows with a hand-written answer are checked against that answer
        pending_results.push_back(typed ? typed_res : res);
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic heap_result_t res_of(input status_t st, input int id,
                                            input logic [KEY_IN_W-1:0] key, input int cnt);
        heap_result_t r;
        r.status = st;
        r.id     = ID_W'(id);
        r.key    = key;
        r.count  = COUNT_W'(cnt);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // result side: checking and receiver stalls
    // ---------------------------------------------------------------
    task automatic report(input string field, input longint got, input longint want);
        mismatches++;
        $display("mismatch on %s at %0t: got %0h expected %0h", field, $realtime, got, want);
    endtask

    initial begin
        int           stall_left;
        int           hold_left;
        heap_result_t want;
        stall_left = 0;
        hold_left  = 0;
        m_ready   <= 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    report("unexpected beat", longint'(m_status), 0);
                end else begin
                    want = pending_results.pop_front();
                    status_hits[m_status]++;
                    if (m_status != want.status)
                        report("status", longint'(m_status), longint'(want.status));
                    if (m_out_id != want.id)
                        report("out_id", longint'(m_out_id), longint'(want.id));
                    if (m_out_key != want.key)
                        report("out_key", longint'(m_out_key), longint'(want.key));
                    if (m_entry_count != want.count)
                        report("entry_count", longint'(m_entry_count), longint'(want.count));
                end
            end
            // pick up a request for a long hold-off from the sender
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
            end
            if (!aresetn) m_ready <= 1'b0;
            else if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) m_ready <= 1'b1;
            else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_ready <= 1'b0;
            end else m_ready <= 1'b1;
        end
    end

    // watchdog: cycles in which no beat moves on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT) begin
            $display("timeout after %0d idle cycles", quiet_cycles);
            $display("FAIL indexed_min_heap_queue");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    heap_row_t directed [$];

    task automatic add_row(input mode_t mode, input int id, input logic [KEY_IN_W-1:0] key,
                           input int rpos, input bit typed, input heap_result_t res);
        heap_row_t r;
        r.mode  = mode;
        r.id    = ID_W'(id);
        r.key   = key;
        r.rpos  = RPOS_W'(rpos);
        r.typed = typed;
        r.res   = res;
        directed.push_back(r);
    endtask

    function automatic logic [KEY_IN_W-1:0] pick_key();
        // narrow keys force ties, wide ones exercise every bit
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(0, 63);
            2:       return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        heap_result_t none;
        mode_t        mode;
        logic [ID_W-1:0] id;
        logic [RPOS_W-1:0] rpos;
        int           fill_phase;
        int           tries;
        none = '0;
        mismatches   = 0;
        results_seen = 0;
        peak_count   = 0;
        shadow_count = 0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        quiet_cycles = 0;
        foreach (shadow_pos[i]) shadow_pos[i] = 0;
        foreach (status_hits[i]) status_hits[i] = 0;
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_mode          <= MODE_INSERT;
        s_item_id       <= '0;
        s_item_key      <= '0;
        s_read_position <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // empty heap corner cases, extremes of id and key, ties at the root
        add_row(MODE_POP,    0,   0,            0,   1, res_of(ST_EMPTY,  0,   0, 0));
        add_row(MODE_REMOVE, 5,   0,            0,   1, res_of(ST_ABSENT, 0,   0, 0));
        add_row(MODE_READ,   0,   0,            0,   1, res_of(ST_RANGE,  0,   0, 0));
        add_row(MODE_READ,   0,   0,            1,   1, res_of(ST_RANGE,  0,   0, 0));
        add_row(MODE_READ,   0,   0,            511, 1, res_of(ST_RANGE,  0,   0, 0));
        add_row(MODE_INSERT, 0,   32'hffffffff, 0,   1, res_of(ST_OK,     0,   0, 1));
        add_row(MODE_INSERT, 255, 32'h0,        0,   1, res_of(ST_OK,     0,   0, 2));
        add_row(MODE_INSERT, 0,   7,            0,   1, res_of(ST_PRESENT, 0,  0, 2));
        add_row(MODE_READ,   0,   0,            1,   1, res_of(ST_OK,     255, 0, 2));
        add_row(MODE_READ,   0,   0,            2,   1,
                res_of(ST_OK, 0, 32'hffffffff, 2));
        add_row(MODE_READ,   0,   0,            3,   1, res_of(ST_RANGE,  0,   0, 2));
        add_row(MODE_INSERT, 10,  0,            0,   0, none);
        add_row(MODE_INSERT, 11,  0,            0,   0, none);
        add_row(MODE_READ,   0,   0,            1,   0, none);
        add_row(MODE_INSERT, 12,  5,            0,   0, none);
        add_row(MODE_INSERT, 13,  5,            0,   0, none);
        add_row(MODE_REMOVE, 255, 0,            0,   0, none);
        add_row(MODE_REMOVE, 255, 0,            0,   0, none);
        add_row(MODE_POP,    0,   0,            0,   0, none);
        add_row(MODE_READ,   0,   0,            4,   0, none);
        add_row(MODE_POP,    0,   0,            0,   0, none);
        add_row(MODE_POP,    0,   0,            0,   0, none);
        add_row(MODE_POP,    0,   0,            0,   0, none);
        add_row(MODE_POP,    0,   0,            0,   0, none);
        add_row(MODE_POP,    0,   0,            0,   1, res_of(ST_EMPTY,  0,   0, 0));

        foreach (directed[i])
            send_beat(directed[i].mode, directed[i].id, directed[i].key, directed[i].rpos,
                      directed[i].typed, directed[i].res);

        // random part: an insert-only stretch fills the heap toward its depth, then a mixed
        // stretch drains and refills it
        for (int n = 0; n < RAND_ITEMS; n++) begin
            fill_phase = (n < 360);
            if (n == 400) hold_req = 1'b1;
            if (n == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:     mode = MODE_INSERT;
                7, 8, 9:                 mode = MODE_REMOVE;
                10, 11, 12:              mode = MODE_POP;
                13, 14:                  mode = MODE_REMOVE;
                15, 16:                  mode = MODE_POP;
                default:                 mode = MODE_READ;
            endcase
            if (fill_phase) mode = MODE_INSERT;
            id = ID_W'($urandom);
            // mostly well-formed: inserts of absent ids, removes of present ones
            tries = 0;
            if (mode == MODE_INSERT && $urandom_range(0, 9) != 0)
                while (id_present(id) && tries < 64) begin
                    id = ID_W'($urandom);
                    tries++;
                end
            else if (mode == MODE_REMOVE && $urandom_range(0, 4) != 0)
                while (!id_present(id) && tries < 64) begin
                    id = ID_W'($urandom);
                    tries++;
                end
            if ($urandom_range(0, 7) == 0) rpos = RPOS_W'($urandom);
            else rpos = RPOS_W'($urandom_range(0, shadow_count + 1));
            send_beat(mode, id, pick_key(), rpos, 0, none);
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);

        $display("covered %0d directed and %0d random requests, %0d results, peak fill %0d",
                 directed.size(), RAND_ITEMS, results_seen, peak_count);
        $display("status counts ok %0d present %0d absent %0d empty %0d full %0d range %0d",
                 status_hits[ST_OK], status_hits[ST_PRESENT], status_hits[ST_ABSENT],
                 status_hits[ST_EMPTY], status_hits[ST_FULL], status_hits[ST_RANGE]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS indexed_min_heap_queue");
        end else begin
            $display("FAIL indexed_min_heap_queue");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/imhq_pkg.sv
rtl/imhq_ram.sv
rtl/imhq_ctrl.sv
rtl/imhq_datapath.sv
rtl/indexed_min_heap_queue.sv
bench/indexed_min_heap_queue_tb.sv
